>>> rtl/wed_pkg.sv
package wed_pkg;

  // Operation codes of the input word; code 3 is accepted and ignored.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_END    = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 4;
  localparam logic [CfgIdxWidth-1:0] CFG_INS       = 4'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DEL       = 4'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SUB_PAIR  = 4'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_SUB_OTHER = 4'd3;

  localparam logic [7:0] INS_RESET       = 8'd2;
  localparam logic [7:0] DEL_RESET       = 8'd2;
  localparam logic [7:0] SUB_PAIR_RESET  = 8'd3;
  localparam logic [7:0] SUB_OTHER_RESET = 8'd4;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_T = 8'h54;

  typedef struct packed {
    logic [7:0] ins;
    logic [7:0] del;
    logic [7:0] sub_pair;
    logic [7:0] sub_other;
  } costs_t;

  // Control part of the token that walks down the row of cells.
  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [7:0] sym;
    costs_t     costs;
    logic       sat;
    logic       err;
  } tok_t;

  function automatic logic [7:0] sub_cost(logic [7:0] a, logic [7:0] b, costs_t c);
    logic pair;
    pair = (a == SYM_A && b == SYM_T) || (a == SYM_T && b == SYM_A) ||
           (a == SYM_C && b == SYM_G) || (a == SYM_G && b == SYM_C);
    if (a == b) begin
      return 8'd0;
    end else if (pair) begin
      return c.sub_pair;
    end else begin
      return c.sub_other;
    end
  endfunction

endpackage

>>> rtl/wed_cell.sv
module wed_cell #(
  parameter int unsigned DIST_WIDTH = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  wed_pkg::tok_t         tok_i,
  input  logic [DIST_WIDTH-1:0] a_i,
  input  logic [DIST_WIDTH-1:0] b_i,
  output wed_pkg::tok_t         tok_o,
  output logic [DIST_WIDTH-1:0] a_o,
  output logic [DIST_WIDTH-1:0] b_o
);
  import wed_pkg::*;

  localparam logic [DIST_WIDTH-1:0] DistMax = {DIST_WIDTH{1'b1}};

  logic                  active_q, active_d;
  logic                  sat_q, sat_d;
  logic [7:0]            ref_q, ref_d;
  logic [DIST_WIDTH-1:0] up_q, up_d;
  tok_t                  tok_q, tok_d;
  logic [DIST_WIDTH-1:0] a_q, a_d, b_q, b_d;

  logic [DIST_WIDTH:0]   s_ins, s_del, s_sub;
  logic [DIST_WIDTH-1:0] c_ins, c_del, c_sub, best;
  logic                  f_ins, f_del, f_sub;

  // Three candidate sums, each clamped at the saturation limit.
  always_comb begin
    s_ins = {1'b0, a_i} + (DIST_WIDTH+1)'(tok_i.costs.ins);
    s_del = {1'b0, up_q} + (DIST_WIDTH+1)'(tok_i.costs.del);
    s_sub = {1'b0, b_i} + (DIST_WIDTH+1)'(sub_cost(tok_i.sym, ref_q, tok_i.costs));
    f_ins = s_ins >= {1'b0, DistMax};
    f_del = s_del >= {1'b0, DistMax};
    f_sub = s_sub >= {1'b0, DistMax};
    c_ins = f_ins ? DistMax : s_ins[DIST_WIDTH-1:0];
    c_del = f_del ? DistMax : s_del[DIST_WIDTH-1:0];
    c_sub = f_sub ? DistMax : s_sub[DIST_WIDTH-1:0];
    best  = c_ins;
    if (c_del < best) begin
      best = c_del;
    end
    if (c_sub < best) begin
      best = c_sub;
    end
  end

  always_comb begin
    active_d = active_q;
    sat_d    = sat_q;
    ref_d    = ref_q;
    up_d     = up_q;
    tok_d    = tok_i;
    a_d      = a_i;
    b_d      = b_i;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_APPEND: begin
          if (!active_q) begin
            // First free cell takes the symbol and ends the token.
            active_d    = 1'b1;
            ref_d       = tok_i.sym;
            up_d        = c_ins;
            sat_d       = sat_q | f_ins;
            tok_d.valid = 1'b0;
          end else begin
            a_d = up_q;
          end
        end
        OP_QUERY: begin
          if (active_q) begin
            up_d  = best;
            sat_d = sat_q | f_ins | f_del | f_sub;
            a_d   = best;
            b_d   = up_q;
          end
        end
        OP_END: begin
          if (active_q) begin
            a_d       = up_q;
            tok_d.sat = tok_i.sat | sat_q;
            active_d  = 1'b0;
            sat_d     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sat_q    <= 1'b0;
      tok_q    <= '0;
    end else if (adv_i) begin
      active_q <= active_d;
      sat_q    <= sat_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ref_q <= ref_d;
      up_q  <= up_d;
      a_q   <= a_d;
      b_q   <= b_d;
    end
  end

  assign tok_o = tok_q;
  assign a_o   = a_q;
  assign b_o   = b_q;

endmodule

>>> rtl/weighted_edit_distance_unit.sv
// A result word is registered: its end token passes every cell's register, then the output register.
// Throughput: one input word per cycle; the row of cells is a systolic wavefront.
// The whole row and the input side hold while a finished result is stalled at the output.
// Reset (asynchronous, active low) restores the cost registers to their defaults and clears
// the length, corner, flags and every cell's active bit at once; there is no clearing pass.
module weighted_edit_distance_unit #(
  parameter int unsigned MAX_REF_LEN = 256,
  parameter int unsigned DIST_WIDTH  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wed_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [7:0]                          symbol_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [DIST_WIDTH-1:0]               distance_o,
  output logic                                saturated_o,
  output logic                                input_error_o
);
  import wed_pkg::*;

  localparam int unsigned LenWidth = $clog2(MAX_REF_LEN + 1);
  localparam logic [DIST_WIDTH-1:0] DistMax = {DIST_WIDTH{1'b1}};

  // Cost registers. They are copied into every token, so a word in flight
  // keeps the costs that held when it was accepted.
  costs_t costs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      costs_q <= '{ins: INS_RESET, del: DEL_RESET,
                   sub_pair: SUB_PAIR_RESET, sub_other: SUB_OTHER_RESET};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INS:       costs_q.ins       <= cfg_data_i;
        CFG_DEL:       costs_q.del       <= cfg_data_i;
        CFG_SUB_PAIR:  costs_q.sub_pair  <= cfg_data_i;
        CFG_SUB_OTHER: costs_q.sub_other <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The row moves as one; it holds only when a result at the output is stalled.
  logic adv;
  logic in_fire;
  logic out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_fire    = in_valid_i && adv;

  // Pair state kept at the head of the row: the reference length, column zero
  // of the table (the corner), and the sticky flags seen at the head.
  logic [LenWidth-1:0]   len_q, len_d;
  logic                  qs_q, qs_d;
  logic [1:0]            err_q, err_d;
  logic                  hsat_q, hsat_d;
  logic [DIST_WIDTH-1:0] corner_q, corner_d;

  logic [DIST_WIDTH:0]   corner_sum;
  logic                  corner_ovf;
  logic [DIST_WIDTH-1:0] corner_next;

  tok_t                  inj_tok;
  logic [DIST_WIDTH-1:0] inj_a, inj_b;

  always_comb begin
    corner_sum  = {1'b0, corner_q} + (DIST_WIDTH+1)'(costs_q.del);
    corner_ovf  = corner_sum >= {1'b0, DistMax};
    corner_next = corner_ovf ? DistMax : corner_sum[DIST_WIDTH-1:0];
  end

  always_comb begin
    len_d         = len_q;
    qs_d          = qs_q;
    err_d         = err_q;
    hsat_d        = hsat_q;
    corner_d      = corner_q;
    inj_tok       = '0;
    inj_tok.op    = op_e'(operation_i);
    inj_tok.sym   = symbol_i;
    inj_tok.costs = costs_q;
    inj_a         = corner_q;
    inj_b         = corner_q;
    if (in_fire) begin
      case (op_e'(operation_i))
        OP_APPEND: begin
          if (qs_q) begin
            err_d[1] = 1'b1;
          end else if (len_q == LenWidth'(MAX_REF_LEN)) begin
            err_d[0] = 1'b1;
          end else begin
            // The token walks to the first free cell, picking up the value
            // of each occupied cell as its left neighbor.
            inj_tok.valid = 1'b1;
            len_d         = len_q + LenWidth'(1);
          end
        end
        OP_QUERY: begin
          qs_d          = 1'b1;
          hsat_d        = hsat_q | corner_ovf;
          corner_d      = corner_next;
          inj_tok.valid = 1'b1;
          inj_a         = corner_next;
        end
        OP_END: begin
          // Each occupied cell replaces the distance with its own value, so
          // the last one wins; an empty reference leaves the corner.
          inj_tok.valid = 1'b1;
          inj_tok.sat   = hsat_q;
          inj_tok.err   = |err_q;
          len_d         = '0;
          qs_d          = 1'b0;
          err_d         = '0;
          hsat_d        = 1'b0;
          corner_d      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      qs_q     <= 1'b0;
      err_q    <= '0;
      hsat_q   <= 1'b0;
      corner_q <= '0;
    end else begin
      len_q    <= len_d;
      qs_q     <= qs_d;
      err_q    <= err_d;
      hsat_q   <= hsat_d;
      corner_q <= corner_d;
    end
  end

  // The row of cells, one per reference column.
  tok_t                  tok_w [MAX_REF_LEN+1];
  logic [DIST_WIDTH-1:0] a_w   [MAX_REF_LEN+1];
  logic [DIST_WIDTH-1:0] b_w   [MAX_REF_LEN+1];

  assign tok_w[0] = inj_tok;
  assign a_w[0]   = inj_a;
  assign b_w[0]   = inj_b;

  for (genvar j = 0; j < MAX_REF_LEN; j++) begin : g_cell
    wed_cell #(
      .DIST_WIDTH(DIST_WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (tok_w[j]),
      .a_i   (a_w[j]),
      .b_i   (b_w[j]),
      .tok_o (tok_w[j+1]),
      .a_o   (a_w[j+1]),
      .b_o   (b_w[j+1])
    );
  end

  // Output register: an end token leaving the last cell becomes the result word.
  tok_t                  tail_tok;
  logic                  out_load;
  logic [DIST_WIDTH-1:0] dist_q;
  logic                  sat_out_q;
  logic                  err_out_q;

  assign tail_tok = tok_w[MAX_REF_LEN];
  assign out_load = adv && tail_tok.valid && (tail_tok.op == OP_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dist_q    <= a_w[MAX_REF_LEN];
      sat_out_q <= tail_tok.sat;
      err_out_q <= tail_tok.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_o    = dist_q;
  assign saturated_o   = sat_out_q;
  assign input_error_o = err_out_q;

endmodule
